// ----- src/idf_pkg.sv -----
// shared types, constants and helpers of the info frame deframer
package idf_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_FLAG       = 3'd0;
	localparam logic [2:0] REG_ESCAPE     = 3'd1;
	localparam logic [2:0] REG_ESC_SECOND = 3'd2;
	localparam logic [2:0] REG_ESC_THIRD  = 3'd3;
	localparam logic [2:0] REG_ADDRESS    = 3'd4;
	localparam logic [2:0] REG_CTRL_ZERO  = 3'd5;
	localparam logic [2:0] REG_CTRL_ONE   = 3'd6;

	// register reset values
	localparam logic [7:0] RST_FLAG       = 8'd126;
	localparam logic [7:0] RST_ESCAPE     = 8'd125;
	localparam logic [7:0] RST_ESC_SECOND = 8'd94;
	localparam logic [7:0] RST_ESC_THIRD  = 8'd93;
	localparam logic [7:0] RST_ADDRESS    = 8'd3;
	localparam logic [7:0] RST_CTRL_ZERO  = 8'd0;
	localparam logic [7:0] RST_CTRL_ONE   = 8'd64;

	localparam logic [11:0] LEN_MAX = 12'hFFF;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} idf_kind_t;

	// one queue entry: all results caused by one received byte
	// the second result, when present, is always a payload byte
	typedef struct packed {
		logic       two;
		idf_kind_t  kind;
		logic [7:0] byte0;
		logic [11:0] len;
		logic       fseq;
		logic       aseq;
		logic [7:0] byte1;
	} idf_entry_t;

	// one output beat
	typedef struct packed {
		idf_kind_t  kind;
		logic [7:0] pbyte;
		logic [11:0] len;
		logic       fseq;
		logic       aseq;
		logic       last;
	} idf_beat_t;

	// saturating length increment
	function automatic logic [11:0] sat_inc(input logic [11:0] c);
		return (c == LEN_MAX) ? c : c + 12'd1;
	endfunction

endpackage

// ----- src/idf_front.sv -----
// front end: configuration registers, frame parser and byte destuffing
module idf_front import idf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       in_ready,
	output logic       q_push,
	output idf_entry_t q_entry
);

	typedef enum logic [6:0] {
		ST_HUNT = 7'b0000001,
		ST_FLAG = 7'b0000010,
		ST_ADDR = 7'b0000100,
		ST_CTRL = 7'b0001000,
		ST_DATA = 7'b0010000,
		ST_ESC1 = 7'b0100000,
		ST_ESC2 = 7'b1000000
	} idf_state_t;

	logic [7:0] flag_q, esc_q, esc2_q, esc3_q, addr_q, ctrl0_q, ctrl1_q;
	idf_state_t state_q, state_n;
	logic        cseq_q, cseq_n;
	logic        hv_q, hv_n;
	logic [7:0]  hb_q, hb_n;
	logic [7:0]  xor_q, xor_n;
	logic [11:0] cnt_q, cnt_n;
	logic        eseq_q, eseq_n;
	logic        push;
	idf_entry_t  ent;
	logic        good;
	logic        acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign q_push   = acc && push;
	assign q_entry  = ent;
	assign good     = hv_q && (hb_q == xor_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= RST_FLAG;
			esc_q   <= RST_ESCAPE;
			esc2_q  <= RST_ESC_SECOND;
			esc3_q  <= RST_ESC_THIRD;
			addr_q  <= RST_ADDRESS;
			ctrl0_q <= RST_CTRL_ZERO;
			ctrl1_q <= RST_CTRL_ONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FLAG:       flag_q  <= cfg_data;
				REG_ESCAPE:     esc_q   <= cfg_data;
				REG_ESC_SECOND: esc2_q  <= cfg_data;
				REG_ESC_THIRD:  esc3_q  <= cfg_data;
				REG_ADDRESS:    addr_q  <= cfg_data;
				REG_CTRL_ZERO:  ctrl0_q <= cfg_data;
				REG_CTRL_ONE:   ctrl1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parser next state and queue entry
	always_comb begin
		state_n = state_q;
		cseq_n  = cseq_q;
		hv_n    = hv_q;
		hb_n    = hb_q;
		xor_n   = xor_q;
		cnt_n   = cnt_q;
		eseq_n  = eseq_q;
		push    = 1'b0;
		ent     = '0;
		ent.kind = KIND_PAYLOAD;
		unique case (state_q)
			ST_HUNT: begin
				if (in_byte == flag_q) state_n = ST_FLAG;
			end
			ST_FLAG: begin
				if (in_byte == addr_q) state_n = ST_ADDR;
				else if (in_byte != flag_q) state_n = ST_HUNT;
			end
			ST_ADDR: begin
				if (in_byte == ctrl0_q || in_byte == ctrl1_q) begin
					cseq_n  = (in_byte != ctrl0_q);
					state_n = ST_CTRL;
				end else if (in_byte == flag_q) begin
					state_n = ST_FLAG;
				end else begin
					state_n = ST_HUNT;
				end
			end
			ST_CTRL: begin
				if (in_byte == (addr_q ^ (cseq_q ? ctrl1_q : ctrl0_q))) begin
					state_n = ST_DATA;
					hv_n    = 1'b0;
					hb_n    = '0;
					xor_n   = '0;
					cnt_n   = '0;
				end else if (in_byte == flag_q) begin
					state_n = ST_FLAG;
				end else begin
					state_n = ST_HUNT;
				end
			end
			ST_DATA: begin
				if (in_byte == esc_q) begin
					state_n = ST_ESC1;
				end else if (in_byte == flag_q) begin
					// closing flag: frame end report
					push      = 1'b1;
					eseq_n    = eseq_q ^ good;
					ent.kind  = good ? KIND_GOOD : KIND_BAD;
					ent.len   = hv_q ? cnt_q : '0;
					ent.fseq  = cseq_q;
					ent.aseq  = eseq_q ^ good;
					state_n   = ST_HUNT;
				end else begin
					// single decoded byte
					push      = hv_q;
					ent.byte0 = hb_q;
					if (hv_q) begin
						xor_n = xor_q ^ hb_q;
						cnt_n = sat_inc(cnt_q);
					end
					hb_n = in_byte;
					hv_n = 1'b1;
				end
			end
			ST_ESC1: begin
				if (in_byte == esc2_q) begin
					state_n = ST_ESC2;
				end else begin
					// escape byte then this byte
					push = 1'b1;
					if (hv_q) begin
						ent.two   = 1'b1;
						ent.byte0 = hb_q;
						ent.byte1 = esc_q;
						xor_n     = xor_q ^ hb_q ^ esc_q;
						cnt_n     = sat_inc(sat_inc(cnt_q));
					end else begin
						ent.byte0 = esc_q;
						xor_n     = xor_q ^ esc_q;
						cnt_n     = sat_inc(cnt_q);
					end
					hb_n    = in_byte;
					hv_n    = 1'b1;
					state_n = ST_DATA;
				end
			end
			ST_ESC2: begin
				state_n = ST_DATA;
				if (in_byte == esc3_q || in_byte == esc_q) begin
					// escaped flag, or escaped escape that opens a new escape
					push      = hv_q;
					ent.byte0 = hb_q;
					if (hv_q) begin
						xor_n = xor_q ^ hb_q;
						cnt_n = sat_inc(cnt_q);
					end
					hv_n = 1'b1;
					if (in_byte == esc3_q) begin
						hb_n = flag_q;
					end else begin
						hb_n    = esc_q;
						state_n = ST_ESC1;
					end
				end else begin
					push = 1'b1;
					if (hv_q) begin
						ent.two   = 1'b1;
						ent.byte0 = hb_q;
						ent.byte1 = esc_q;
						xor_n     = xor_q ^ hb_q ^ esc_q;
						cnt_n     = sat_inc(sat_inc(cnt_q));
					end else begin
						ent.byte0 = esc_q;
						xor_n     = xor_q ^ esc_q;
						cnt_n     = sat_inc(cnt_q);
					end
					hb_n = in_byte;
					hv_n = 1'b1;
				end
			end
			default: state_n = ST_HUNT;
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			cseq_q  <= 1'b0;
			hv_q    <= 1'b0;
			hb_q    <= '0;
			xor_q   <= '0;
			cnt_q   <= '0;
			eseq_q  <= 1'b0;
		end else if (acc) begin
			state_q <= state_n;
			cseq_q  <= cseq_n;
			hv_q    <= hv_n;
			hb_q    <= hb_n;
			xor_q   <= xor_n;
			cnt_q   <= cnt_n;
			eseq_q  <= eseq_n;
		end
	end

endmodule

// ----- src/idf_queue.sv -----
// short queue of result entries between front and back
module idf_queue import idf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  idf_entry_t push_data,
	input  logic       pop,
	output idf_entry_t pop_data,
	output logic       full,
	output logic       empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	idf_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ----- src/idf_back.sv -----
// back end: splits queue entries into output beats behind an output register
module idf_back import idf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  idf_entry_t q_data,
	input  logic       q_empty,
	output logic       q_pop,
	input  logic       out_ready,
	output logic       out_valid,
	output idf_beat_t  out_beat
);

	logic       valid_q;
	idf_beat_t  beat_q;
	logic       pend_q;
	logic [7:0] pend_byte_q;
	logic       adv;

	assign adv       = !valid_q || out_ready;
	assign q_pop     = adv && !pend_q && !q_empty;
	assign out_valid = valid_q;
	assign out_beat  = beat_q;

	// output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (adv) begin
			priority if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				pend_q  <= q_data.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			priority if (pend_q) begin
				beat_q.kind  <= KIND_PAYLOAD;
				beat_q.pbyte <= pend_byte_q;
				beat_q.len   <= '0;
				beat_q.fseq  <= 1'b0;
				beat_q.aseq  <= 1'b0;
				beat_q.last  <= 1'b1;
			end else if (!q_empty) begin
				beat_q.kind  <= q_data.kind;
				beat_q.pbyte <= q_data.byte0;
				beat_q.len   <= q_data.len;
				beat_q.fseq  <= q_data.fseq;
				beat_q.aseq  <= q_data.aseq;
				beat_q.last  <= !q_data.two;
				pend_byte_q  <= q_data.byte1;
			end
		end
	end

endmodule

// ----- src/info_frame_deframer_top.sv -----
// top level of the information frame deframer
// Takes one received serial byte per request and reports destuffed payload
// bytes and frame end results (good or bad, length, frame and acknowledge
// sequence). A byte is accepted every cycle while the result queue has room;
// each byte yields zero, one or two output beats, and the output port moves
// one beat per cycle while the receiver is ready, so the sustained byte rate is
// set by the output port and drops where an escape pair decodes to two bytes.
// The first result of a byte reaches the output through the result queue,
// written when the byte is accepted, and then the output register.
module info_frame_deframer_top import idf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // payload_byte[7:0], frame_length[19:8],
	                               // frame_seq[20], ack_seq[21], zero[23:22]
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);

	logic       q_push, q_pop, q_full, q_empty;
	idf_entry_t q_in, q_out;
	idf_beat_t  beat;

	assign cfg_ready = 1'b1;

	// parser and destuffing
	idf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.q_full    (q_full),
		.in_ready  (s_tready),
		.q_push    (q_push),
		.q_entry   (q_in)
	);

	// result queue
	idf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.full      (q_full),
		.empty     (q_empty)
	);

	// beat output
	idf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_out),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_beat  (beat)
	);

	// output packing
	assign m_tdata = {2'b00, beat.aseq, beat.fseq, beat.len, beat.pbyte};
	assign m_tuser = beat.kind;
	assign m_tlast = beat.last;

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench of the information frame deframer
module testbench;
	import idf_pkg::*;

	// decoder phases of the expected-result tracker
	typedef enum logic [2:0] {
		PS_HUNT, PS_FLAG, PS_ADDR, PS_CTRL, PS_DATA, PS_ESC1, PS_ESC2
	} parse_state_t;

	localparam logic [2:0] REG_ORDER [7] = '{REG_FLAG, REG_ESCAPE, REG_ESC_SECOND,
		REG_ESC_THIRD, REG_ADDRESS, REG_CTRL_ZERO, REG_CTRL_ONE};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_FLAG;
	logic [7:0]  cfg_data = 8'h00;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	info_frame_deframer_top dut (.*);

	// register copy and decoder state tracked alongside the block
	logic [7:0]   regs [7] = '{RST_FLAG, RST_ESCAPE, RST_ESC_SECOND, RST_ESC_THIRD,
		RST_ADDRESS, RST_CTRL_ZERO, RST_CTRL_ONE};
	parse_state_t dec_state = PS_HUNT;
	logic         frame_seq_r = 1'b0;
	logic         held_ok = 1'b0;
	logic [7:0]   held_b = 8'h00;
	logic [7:0]   xor_acc = 8'h00;
	logic [11:0]  pay_count = 12'd0;
	logic         ack_bit = 1'b0;

	idf_beat_t pending_beats [$];
	idf_beat_t seen_beat, due_beat;

	int mismatches = 0;
	int rx_sent = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#(12 * 600000);
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) $display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic void add_beat(input idf_kind_t k, input logic [7:0] pb,
			input logic [11:0] n, input logic fs, input logic ack);
		idf_beat_t bt;
		bt.kind = k;
		bt.pbyte = pb;
		bt.len = n;
		bt.fseq = fs;
		bt.aseq = ack;
		bt.last = 1'b0;
		pending_beats.push_back(bt);
	endfunction

	// a decoded byte pushes out the one held back before it
	function automatic void take_decoded(input logic [7:0] b);
		if (held_ok) begin
			add_beat(KIND_PAYLOAD, held_b, 12'd0, 1'b0, 1'b0);
			xor_acc = xor_acc ^ held_b;
			if (pay_count != LEN_MAX) pay_count = pay_count + 12'd1;
		end
		held_b = b;
		held_ok = 1'b1;
	endfunction

	// closing flag: held byte must equal the xor of the bytes before it
	function automatic void end_of_frame();
		if (held_ok && held_b == xor_acc) begin
			ack_bit = ~ack_bit;
			add_beat(KIND_GOOD, 8'h00, pay_count, frame_seq_r, ack_bit);
		end else begin
			add_beat(KIND_BAD, 8'h00, held_ok ? pay_count : 12'd0, frame_seq_r, ack_bit);
		end
		dec_state = PS_HUNT;
	endfunction

	// expected beats for one accepted byte
	function automatic void deframe_rx_byte(input logic [7:0] b);
		logic [7:0] ctrl;
		int         first;
		idf_beat_t  bt;
		first = pending_beats.size();
		case (dec_state)
			PS_HUNT: begin
				if (b == regs[REG_FLAG]) dec_state = PS_FLAG;
			end
			PS_FLAG: begin
				if (b == regs[REG_ADDRESS]) dec_state = PS_ADDR;
				else if (b != regs[REG_FLAG]) dec_state = PS_HUNT;
			end
			PS_ADDR: begin
				if (b == regs[REG_CTRL_ZERO] || b == regs[REG_CTRL_ONE]) begin
					frame_seq_r = (b == regs[REG_CTRL_ZERO]) ? 1'b0 : 1'b1;
					dec_state = PS_CTRL;
				end else if (b == regs[REG_FLAG]) begin
					dec_state = PS_FLAG;
				end else begin
					dec_state = PS_HUNT;
				end
			end
			PS_CTRL: begin
				ctrl = frame_seq_r ? regs[REG_CTRL_ONE] : regs[REG_CTRL_ZERO];
				if (b == (regs[REG_ADDRESS] ^ ctrl)) begin
					dec_state = PS_DATA;
					held_ok = 1'b0;
					held_b = 8'h00;
					xor_acc = 8'h00;
					pay_count = 12'd0;
				end else if (b == regs[REG_FLAG]) begin
					dec_state = PS_FLAG;
				end else begin
					dec_state = PS_HUNT;
				end
			end
			PS_DATA: begin
				if (b == regs[REG_ESCAPE]) dec_state = PS_ESC1;
				else if (b == regs[REG_FLAG]) end_of_frame();
				else take_decoded(b);
			end
			PS_ESC1: begin
				if (b == regs[REG_ESC_SECOND]) begin
					dec_state = PS_ESC2;
				end else begin
					take_decoded(regs[REG_ESCAPE]);
					take_decoded(b);
					dec_state = PS_DATA;
				end
			end
			PS_ESC2: begin
				dec_state = PS_DATA;
				if (b == regs[REG_ESC_THIRD]) begin
					take_decoded(regs[REG_FLAG]);
				end else if (b == regs[REG_ESCAPE]) begin
					take_decoded(regs[REG_ESCAPE]);
					dec_state = PS_ESC1;
				end else begin
					take_decoded(regs[REG_ESCAPE]);
					take_decoded(b);
				end
			end
			default: begin
				dec_state = PS_HUNT;
			end
		endcase
		// mark the final beat of this byte
		if (pending_beats.size() > first) begin
			bt = pending_beats.pop_back();
			bt.last = 1'b1;
			pending_beats.push_back(bt);
		end
	endfunction

	// check output beats, track register writes and accepted bytes
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen_beat.kind = idf_kind_t'(m_tuser);
				seen_beat.pbyte = m_tdata[7:0];
				seen_beat.len = m_tdata[19:8];
				seen_beat.fseq = m_tdata[20];
				seen_beat.aseq = m_tdata[21];
				seen_beat.last = m_tlast;
				if (pending_beats.size() == 0) begin
					report_mismatch($sformatf("beat with nothing due: kind %0d byte %02h len %0d",
						m_tuser, m_tdata[7:0], m_tdata[19:8]));
				end else begin
					due_beat = pending_beats.pop_front();
					if (seen_beat !== due_beat || m_tdata[23:22] !== 2'b00)
						report_mismatch($sformatf({"kind/byte/len/fseq/aseq/last got ",
							"%0d/%02h/%0d/%0d/%0d/%0d want %0d/%02h/%0d/%0d/%0d/%0d pad %b"},
							m_tuser, seen_beat.pbyte, seen_beat.len, seen_beat.fseq,
							seen_beat.aseq, seen_beat.last, due_beat.kind, due_beat.pbyte,
							due_beat.len, due_beat.fseq, due_beat.aseq, due_beat.last,
							m_tdata[23:22]));
				end
			end
			if (cfg_valid && cfg_ready) regs[cfg_index] = cfg_data;
			if (s_tvalid && s_tready) deframe_rx_byte(s_tdata);
		end
	end

	// output ready: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req <= 0;
		end
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one byte request; valid stays high for a following byte
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		rx_sent++;
	endtask

	task automatic send_bytes(input logic [7:0] q [$]);
		foreach (q[i]) send_byte(q[i]);
	endtask

	// stop sending and let every due beat come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic load_regs(input logic [7:0] vals [7]);
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// random byte that is not the flag, and optionally not the escape either
	function automatic logic [7:0] pick_byte(input bit allow_escape);
		logic [7:0] b;
		b = 8'($urandom_range(255));
		while (b == regs[REG_FLAG] || (!allow_escape && b == regs[REG_ESCAPE]))
			b = 8'($urandom_range(255));
		return b;
	endfunction

	// trailer that makes the frame good (unless spoiled, or it equals the escape and is not sent), then the closing flag
	task automatic close_with_trailer(input bit spoil);
		logic [7:0] t;
		t = xor_acc ^ (held_ok ? held_b : 8'h00);
		if (spoil) t = t ^ 8'($urandom_range(1, 255));
		if (t == regs[REG_FLAG]) begin
			send_byte(regs[REG_ESCAPE]);
			send_byte(regs[REG_ESC_SECOND]);
			send_byte(regs[REG_ESC_THIRD]);
		end else if (t != regs[REG_ESCAPE]) begin
			send_byte(t);
		end
		send_byte(regs[REG_FLAG]);
	endtask

	// full frame: header, n payload items with random escapes, trailer, flag
	task automatic send_frame(input int n, input bit spoil);
		logic [7:0] c, b;
		int         p;
		if ($urandom_range(9) == 0) send_byte(regs[REG_FLAG]);
		c = $urandom_range(1) ? regs[REG_CTRL_ONE] : regs[REG_CTRL_ZERO];
		send_byte(regs[REG_FLAG]);
		send_byte(regs[REG_ADDRESS]);
		send_byte(c);
		send_byte(regs[REG_ADDRESS] ^ c);
		if (dec_state != PS_DATA) return;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			if (p < 72) begin
				send_byte(pick_byte(1'b0));
			end else if (p < 82) begin
				send_byte(regs[REG_ESCAPE]);
				send_byte(regs[REG_ESC_SECOND]);
				send_byte(regs[REG_ESC_THIRD]);
			end else if (p < 90) begin
				send_byte(regs[REG_ESCAPE]);
				send_byte(8'($urandom_range(255)));
			end else if (p < 96) begin
				send_byte(regs[REG_ESCAPE]);
				send_byte(regs[REG_ESC_SECOND]);
				send_byte(8'($urandom_range(255)));
			end else begin
				send_byte(pick_byte(1'b1));
			end
		end
		// leave any open escape before the trailer
		while (dec_state == PS_ESC1 || dec_state == PS_ESC2) begin
			b = 8'($urandom_range(255));
			if (b != regs[REG_ESCAPE] && b != regs[REG_ESC_SECOND]) send_byte(b);
		end
		if (dec_state == PS_DATA) close_with_trailer(spoil);
	endtask

	// header cut short or corrupted
	task automatic send_broken();
		logic [7:0] c;
		c = $urandom_range(1) ? regs[REG_CTRL_ONE] : regs[REG_CTRL_ZERO];
		send_byte(regs[REG_FLAG]);
		case ($urandom_range(3))
			0: begin
				send_byte(8'($urandom_range(255)));
			end
			1: begin
				send_byte(regs[REG_ADDRESS]);
				send_byte(8'($urandom_range(255)));
			end
			2: begin
				send_byte(regs[REG_ADDRESS]);
				send_byte(c);
				send_byte(8'($urandom_range(255)));
			end
			default: begin
				send_byte(regs[REG_ADDRESS]);
				send_byte(c);
				send_byte(regs[REG_FLAG]);
			end
		endcase
	endtask

	// header hunt, every escape form, empty frame, good frame of length zero
	task automatic test_directed_cases();
		logic [7:0] q [$];
		send_gap_pct = 0;
		recv_stall_pct = 0;
		// repeated flag, flag in control phase, then control one header
		q = '{8'h7E, 8'h7E, 8'h03, 8'h00, 8'h7E, 8'h03, 8'h40, 8'h43,
			8'hFF, 8'h00, 8'h7D, 8'h5E, 8'h5D, 8'h7D, 8'h5E, 8'h7D, 8'h11,
			8'h7D, 8'h5E, 8'h22, 8'h7D, 8'h7E};
		send_bytes(q);
		close_with_trailer(1'b0);
		// closing flag does not open a frame; then an empty and a zero frame
		q = '{8'h03, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h7E,
			8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h7E};
		send_bytes(q);
		wait_idle();
	endtask

	task automatic test_register_settings();
		logic [7:0] setting [7];
		send_gap_pct = 38;
		recv_stall_pct = 38;
		for (int k = 0; k < 5; k++) begin
			case (k)
				0: setting = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'h80, 8'h80};
				1: setting = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
				4: setting = '{RST_FLAG, RST_ESCAPE, RST_ESC_SECOND, RST_ESC_THIRD,
					RST_ADDRESS, RST_CTRL_ZERO, RST_CTRL_ONE};
				default: begin
					foreach (setting[i]) setting[i] = 8'($urandom_range(255));
					while (setting[1] == setting[0]) setting[1] = 8'($urandom_range(255));
				end
			endcase
			load_regs(setting);
			repeat (12) send_frame($urandom_range(0, 10), $urandom_range(99) < 20);
			repeat (2) send_broken();
			wait_idle();
		end
	endtask

	// escape byte changed while a frame is open
	task automatic test_write_inside_frame();
		logic [7:0] setting [7];
		logic [7:0] q [$];
		send_gap_pct = 0;
		recv_stall_pct = 0;
		q = '{RST_FLAG, RST_ADDRESS, RST_CTRL_ZERO, RST_ADDRESS ^ RST_CTRL_ZERO,
			8'h31, 8'h32, 8'h33};
		send_bytes(q);
		wait_idle();
		setting = '{RST_FLAG, 8'h55, RST_ESC_SECOND, RST_ESC_THIRD,
			RST_ADDRESS, RST_CTRL_ZERO, RST_CTRL_ONE};
		load_regs(setting);
		q = '{8'h55, 8'h5E, 8'h5D, 8'h55, 8'h7D, 8'h7D};
		send_bytes(q);
		close_with_trailer(1'b0);
		wait_idle();
		setting[1] = RST_ESCAPE;
		load_regs(setting);
	endtask

	// long output hold-off while bytes keep coming
	task automatic test_output_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_req <= 300;
		send_frame(40, 1'b0);
		send_frame(6, 1'b0);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int first, p, n;
		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct = (ph == 1) ? 54 : (ph == 3) ? 38 : 0;
			recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 38 : 0;
			first = rx_sent;
			while (rx_sent - first < 115) begin
				p = $urandom_range(99);
				if (p < 80) begin
					n = $urandom_range(99);
					n = (n < 70) ? $urandom_range(0, 8) :
						(n < 95) ? $urandom_range(9, 30) : $urandom_range(31, 80);
					send_frame(n, $urandom_range(99) < 15);
				end else if (p < 92) begin
					send_broken();
				end else begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
				end
			end
			wait_idle();
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_register_settings();
		test_write_inside_frame();
		test_output_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
